[rtl/source_text_tokenizer_assert.svh]
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
// implication check under synchronous reset
`define STT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication check
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/stt_pkg.sv]
`timescale 1ns / 1ps
package stt_pkg;
   localparam int DefaultPositionBits = 16;
   localparam int KwCount = 18;
   localparam int MaxResults = 3;

   localparam logic [3:0] M_IDLE       = 4'd0;
   localparam logic [3:0] M_IDENT      = 4'd1;
   localparam logic [3:0] M_NUMBER     = 4'd2;
   localparam logic [3:0] M_NUM_DOT    = 4'd3;
   localparam logic [3:0] M_REAL       = 4'd4;
   localparam logic [3:0] M_TEXT       = 4'd5;
   localparam logic [3:0] M_CHAR_OPEN  = 4'd6;
   localparam logic [3:0] M_CHAR_VALUE = 4'd7;
   localparam logic [3:0] M_HASH1      = 4'd8;
   localparam logic [3:0] M_LINE       = 4'd9;
   localparam logic [3:0] M_BLOCK      = 4'd10;
   localparam logic [3:0] M_BLOCK_HASH = 4'd11;
   localparam logic [3:0] M_OP         = 4'd12;

   localparam logic [5:0] K_EOF     = 6'd0;
   localparam logic [5:0] K_ERR     = 6'd1;
   localparam logic [5:0] K_IDENT   = 6'd2;
   localparam logic [5:0] K_NUMB    = 6'd3;
   localparam logic [5:0] K_REAL    = 6'd4;
   localparam logic [5:0] K_BOOL    = 6'd5;
   localparam logic [5:0] K_TEXT    = 6'd6;
   localparam logic [5:0] K_CHAR    = 6'd7;
   localparam logic [5:0] K_COMMENT = 6'd8;
   localparam logic [5:0] K_DOT     = 6'd32;

   localparam logic [3:0] E_NONE       = 4'd0;
   localparam logic [3:0] E_UNEXPECTED = 4'd1;
   localparam logic [3:0] E_LONE_AMP   = 4'd2;
   localparam logic [3:0] E_LONE_BAR   = 4'd3;
   localparam logic [3:0] E_TEXT_OPEN  = 4'd4;
   localparam logic [3:0] E_CHAR_EMPTY = 4'd5;
   localparam logic [3:0] E_CHAR_OPEN  = 4'd6;
   localparam logic [3:0] E_BLOCK_OPEN = 4'd7;
   localparam logic [3:0] E_OVERFLOW   = 4'd8;

   localparam logic [KwCount-1:0] AllHits = '1;
   localparam logic [31:0] AccOvf = 32'h8000_0000;
   localparam logic [31:0] AccMax = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [5:0]  kind;
      logic [3:0]  err;
      logic [31:0] line;
      logic [31:0] col;
      logic [31:0] len;
      logic [30:0] ival;
      logic        bval;
      logic [7:0]  cval;
   } token_type;

   function automatic logic [7:0] kw_char(input int k, input int p);
      logic [63:0] s;
      s = 64'd0;
      unique case (k)
         0: s = {8'h6b, 8'h6e, 8'h75, 8'h66};
         1: s = "atad";
         2: s = "tum";
         3: s = "fi";
         4: s = "esle";
         5: s = "elihw";
         6: s = "hctam";
         7: s = "esac";
         8: s = "enon";
         9: s = "nruter";
         10: s = "edulcni";
         11: s = "bmun";
         12: s = "laer";
         13: s = "loob";
         14: s = "rahc";
         15: s = "txet";
         16: s = "eurt";
         17: s = "eslaf";
         default: s = 64'd0;
      endcase
      return s[p*8 +: 8];
   endfunction

   function automatic logic [2:0] kw_len(input int k);
      unique case (k)
         2: return 3'd3;
         3: return 3'd2;
         5, 6, 17: return 3'd5;
         9: return 3'd6;
         10: return 3'd7;
         default: return 3'd4;
      endcase
   endfunction

   function automatic logic digit_char(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic alpha_char(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction
endpackage

[rtl/stt_kw_match.sv]
`timescale 1ns / 1ps
module stt_kw_match
   import stt_pkg::*;
(
   input  logic [KwCount-1:0] hits,
   input  logic [7:0]         byte_in,
   input  logic [31:0]        pos,
   input  logic [31:0]        len,
   output logic [KwCount-1:0] hits_next,
   output logic [5:0]         kind,
   output logic               bval
);
   always_comb begin
      hits_next = '0;
      for (int k = 0; k < KwCount; k++) begin
         hits_next[k] = hits[k] && pos < 32'(kw_len(k)) && kw_char(k, int'(pos[2:0])) == byte_in;
      end
   end

   always_comb begin
      kind = K_IDENT;
      bval = 1'b0;
      for (int k = KwCount - 1; k >= 0; k--) begin
         if (hits[k] && len == 32'(kw_len(k))) begin
            kind = (k >= 16) ? K_BOOL : 6'(k + 9);
            bval = (k == 16);
         end
      end
   end
endmodule

[rtl/source_text_tokenizer.sv]
`timescale 1ns / 1ps
// Byte-stream tokenizer: one source byte per cycle enters on req_ and yields zero to three
// tokens on rsp_, the last flagged by rsp_tlast. A byte is taken every cycle unless tokens
// from an earlier byte still wait; the limit is the single result queue, which holds three.
// The first token appears in the cycle after acceptance. Set req_tlast on the final byte;
// the scanner then flushes and restarts at line 1, column 1.
module source_text_tokenizer
   import stt_pkg::*;
#(
   parameter int POSITION_BITS = DefaultPositionBits,
   localparam int RspBits = ((6 + 4 + 3 * POSITION_BITS + 31 + 1 + 8 + 7) / 8) * 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // source_byte
   input  logic        req_tlast,  // end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [RspBits-1:0] rsp_tdata,
   // token_kind, error_kind, line_number_out, start_column, token_length, integer_value,
   // bool_value, char_value (zero padded)
   output logic        rsp_tlast   // last_of_run
);
   localparam int PB = POSITION_BITS;
   localparam logic [31:0] PosMax = 32'((64'd1 << PB) - 64'd1);

   logic [3:0]  mode_ff, mode_in;
   logic [7:0]  held_ff, held_in, prev_ff, prev_in;
   logic [31:0] line_ff, line_in, col_ff, col_in, tcol_ff, tcol_in, len_ff, len_in;
   logic [31:0] acc_ff, acc_in;
   logic [KwCount-1:0] hits_ff, hits_in;
   logic        space_ff, space_in;

   token_type   tok [MaxResults];
   logic [1:0]  ntok;
   token_type   q_ff [MaxResults];
   logic [1:0]  qcnt_ff, qhead_ff;

   logic [KwCount-1:0] kw_next;
   logic [5:0]  kw_kind;
   logic        kw_bval;
   logic [7:0]  b;
   logic        fire;

   assign b = req_tdata;
   assign fire = req_tvalid && req_tready;
   assign req_tready = (qcnt_ff == 2'd0) || (qcnt_ff == 2'd1 && rsp_tready);

   stt_kw_match u_kw (
      .hits(hits_ff), .byte_in(b), .pos(len_ff), .len(len_ff),
      .hits_next(kw_next), .kind(kw_kind), .bval(kw_bval)
   );

   function automatic logic [31:0] inc(input logic [31:0] v);
      return (v < PosMax) ? v + 32'd1 : PosMax;
   endfunction

   function automatic logic [31:0] dot_col(input logic [31:0] tc, input logic [31:0] ln);
      logic [32:0] cw;
      cw = {1'b0, tc} + {1'b0, ln} - 33'd1;
      return (cw > {1'b0, PosMax}) ? PosMax : cw[31:0];
   endfunction

   function automatic logic [5:0] fin_kind(input logic [KwCount-1:0] h,
                                           input logic [31:0] l);
      logic [5:0] r;
      r = K_IDENT;
      for (int k = KwCount - 1; k >= 0; k--) begin
         if (h[k] && l == 32'(kw_len(k))) r = (k >= 16) ? K_BOOL : 6'(k + 9);
      end
      return r;
   endfunction

   function automatic token_type op_tok(input logic [7:0] h, input logic [31:0] ln,
                                        input logic [31:0] cl, input logic [31:0] lg);
      token_type t;
      t = '{K_ERR, E_LONE_BAR, ln, cl, lg, 31'd0, 1'b0, 8'd0};
      unique case (h)
         "+": t.kind = 6'd36;
         "-": t.kind = 6'd38;
         "*": t.kind = 6'd40;
         "/": t.kind = 6'd42;
         "!": t.kind = 6'd44;
         "=": t.kind = 6'd46;
         "<": t.kind = 6'd48;
         ">": t.kind = 6'd50;
         "&": t.err = E_LONE_AMP;
         default: t.kind = K_ERR;
      endcase
      if (t.kind != K_ERR) t.err = E_NONE;
      return t;
   endfunction

   always_comb begin
      logic start;
      logic [31:0] v;
      logic [5:0] pk;
      logic [63:0] prod;
      logic [31:0] c;
      mode_in = mode_ff; held_in = held_ff; prev_in = prev_ff; line_in = line_ff;
      col_in = col_ff; tcol_in = tcol_ff; len_in = len_ff; acc_in = acc_ff;
      hits_in = hits_ff; space_in = space_ff;
      ntok = 2'd0;
      for (int i = 0; i < MaxResults; i++) tok[i] = '0;
      start = 1'b0;
      v = 32'd0; pk = 6'd0; prod = 64'd0; c = 32'd0;

      unique case (mode_ff)
         M_IDENT: begin
            if (digit_char(b) || alpha_char(b)) begin
               hits_in = kw_next; len_in = inc(len_ff); col_in = inc(col_ff);
            end else begin
               tok[ntok] = '{kw_kind, E_NONE, line_ff, tcol_ff, len_ff, 31'd0, kw_bval, 8'd0};
               ntok++; start = 1'b1;
            end
         end
         M_NUMBER: begin
            if (digit_char(b)) begin
               if (!acc_ff[31]) begin
                  prod = {32'd0, acc_ff} * 64'd10 + 64'(b - 8'h30);
                  acc_in = (prod > 64'(AccMax)) ? AccOvf : prod[31:0];
               end
               len_in = inc(len_ff); col_in = inc(col_ff);
            end else if (b == ".") begin
               len_in = inc(len_ff); col_in = inc(col_ff); mode_in = M_NUM_DOT;
            end else begin
               tok[ntok] = acc_ff[31]
                  ? '{K_ERR, E_OVERFLOW, line_ff, tcol_ff, len_ff, 31'd0, 1'b0, 8'd0}
                  : '{K_NUMB, E_NONE, line_ff, tcol_ff, len_ff, acc_ff[30:0], 1'b0, 8'd0};
               ntok++; start = 1'b1;
            end
         end
         M_NUM_DOT: begin
            if (digit_char(b)) begin
               len_in = inc(len_ff); col_in = inc(col_ff); mode_in = M_REAL;
            end else begin
               tok[ntok] = acc_ff[31]
                  ? '{K_ERR, E_OVERFLOW, line_ff, tcol_ff, len_ff - 32'd1, 31'd0, 1'b0, 8'd0}
                  : '{K_NUMB, E_NONE, line_ff, tcol_ff, len_ff - 32'd1, acc_ff[30:0],
                      1'b0, 8'd0};
               ntok++;
               c = dot_col(tcol_ff, len_ff);
               tok[ntok] = '{K_DOT, E_NONE, line_ff, c, 32'd1, 31'd0, 1'b0, 8'd0};
               ntok++; start = 1'b1;
            end
         end
         M_REAL: begin
            if (digit_char(b)) begin
               len_in = inc(len_ff); col_in = inc(col_ff);
            end else begin
               tok[ntok] = '{K_REAL, E_NONE, line_ff, tcol_ff, len_ff, 31'd0, 1'b0, 8'd0};
               ntok++; start = 1'b1;
            end
         end
         M_TEXT: begin
            len_in = inc(len_ff); col_in = inc(col_ff);
            if (b == 8'h22 && prev_ff != 8'h5c) begin
               tok[ntok] = '{K_TEXT, E_NONE, line_ff, tcol_ff, inc(len_ff), 31'd0, 1'b0, 8'd0};
               ntok++; mode_in = M_IDLE;
            end else begin
               prev_in = b;
            end
         end
         M_CHAR_OPEN: begin
            if (b == 8'h27) begin
               tok[ntok] = '{K_ERR, E_CHAR_EMPTY, line_ff, tcol_ff, len_ff, 31'd0, 1'b0, 8'd0};
               ntok++; start = 1'b1;
            end else begin
               held_in = b; len_in = inc(len_ff); col_in = inc(col_ff); mode_in = M_CHAR_VALUE;
            end
         end
         M_CHAR_VALUE: begin
            if (b == 8'h27) begin
               len_in = inc(len_ff); col_in = inc(col_ff);
               tok[ntok] = '{K_CHAR, E_NONE, line_ff, tcol_ff, inc(len_ff), 31'd0, 1'b0, held_ff};
               ntok++; mode_in = M_IDLE;
            end else begin
               tok[ntok] = '{K_ERR, E_CHAR_OPEN, line_ff, tcol_ff, len_ff, 31'd0, 1'b0, 8'd0};
               ntok++; start = 1'b1;
            end
         end
         M_HASH1, M_LINE: begin
            if (b == 8'h0a) begin
               tok[ntok] = '{K_COMMENT, E_NONE, line_ff, tcol_ff, len_ff, 31'd0, 1'b0, 8'd0};
               ntok++; start = 1'b1;
            end else begin
               len_in = inc(len_ff); col_in = inc(col_ff);
               if (mode_ff == M_HASH1) mode_in = (b == "#") ? M_BLOCK : M_LINE;
            end
         end
         M_BLOCK: begin
            len_in = inc(len_ff); col_in = inc(col_ff);
            if (b == "#") mode_in = M_BLOCK_HASH;
         end
         M_BLOCK_HASH: begin
            len_in = inc(len_ff); col_in = inc(col_ff);
            if (b == "#") begin
               tok[ntok] = '{K_COMMENT, E_NONE, line_ff, tcol_ff, inc(len_ff), 31'd0, 1'b0,
                             8'd0};
               ntok++; mode_in = M_IDLE;
            end else begin
               mode_in = M_BLOCK;
            end
         end
         M_OP: begin
            pk = 6'd0;
            if (b == "=") begin
               unique case (held_ff)
                  "+": pk = 6'd37;
                  "-": pk = 6'd39;
                  "*": pk = 6'd41;
                  "/": pk = 6'd43;
                  "!": pk = 6'd45;
                  "=": pk = 6'd47;
                  "<": pk = 6'd49;
                  ">": pk = 6'd51;
                  default: pk = 6'd0;
               endcase
            end
            if (held_ff == ">" && b == ">") pk = 6'd52;
            if (held_ff == "&" && b == "&") pk = 6'd53;
            if (held_ff == "|" && b == "|") pk = 6'd54;
            if (pk != 6'd0) begin
               len_in = inc(len_ff); col_in = inc(col_ff);
               tok[ntok] = '{pk, E_NONE, line_ff, tcol_ff, inc(len_ff), 31'd0, 1'b0, 8'd0};
               ntok++; mode_in = M_IDLE;
            end else begin
               tok[ntok] = op_tok(held_ff, line_ff, tcol_ff, len_ff);
               ntok++; start = 1'b1;
            end
         end
         default: start = 1'b1;
      endcase

      if (start) begin
         mode_in = M_IDLE;
         if (b == " " || b == 8'h0d || b == 8'h09) begin
            col_in = inc(col_ff); space_in = 1'b1;
         end else if (b == 8'h0a) begin
            line_in = inc(line_ff); col_in = 32'd1; space_in = 1'b1;
         end else begin
            space_in = 1'b0; tcol_in = col_ff; len_in = 32'd1; col_in = inc(col_ff);
            if (digit_char(b)) begin
               acc_in = 32'(b - 8'h30); mode_in = M_NUMBER;
            end else if (alpha_char(b)) begin
               for (int k = 0; k < KwCount; k++) hits_in[k] = (kw_char(k, 0) == b);
               mode_in = M_IDENT;
            end else if (b == 8'h22) begin
               prev_in = b; mode_in = M_TEXT;
            end else if (b == 8'h27) begin
               mode_in = M_CHAR_OPEN;
            end else if (b == "#") begin
               mode_in = M_HASH1;
            end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "!" ||
                         b == "=" || b == "<" || b == ">" || b == "&" || b == "|") begin
               held_in = b; mode_in = M_OP;
            end else begin
               unique case (b)
                  "(": pk = 6'd25;
                  ")": pk = 6'd26;
                  "{": pk = 6'd27;
                  "}": pk = 6'd28;
                  "[": pk = 6'd29;
                  "]": pk = 6'd30;
                  ",": pk = 6'd31;
                  ".": pk = K_DOT;
                  ";": pk = 6'd33;
                  "%": pk = 6'd34;
                  "^": pk = 6'd35;
                  default: pk = 6'd0;
               endcase
               tok[ntok] = (pk != 6'd0)
                  ? '{pk, E_NONE, line_ff, col_ff, 32'd1, 31'd0, 1'b0, 8'd0}
                  : '{K_ERR, E_UNEXPECTED, line_ff, col_ff, 32'd1, 31'd0, 1'b0, 8'd0};
               ntok++;
            end
         end
      end

      if (req_tlast) begin
         v = line_in;
         unique case (mode_in)
            M_IDLE: if (space_in) begin
               tok[ntok] = '{K_EOF, E_NONE, v, col_in, 32'd0, 31'd0, 1'b0, 8'd0}; ntok++;
            end
            M_IDENT: begin
               tok[ntok] = '{fin_kind(hits_in, len_in), E_NONE, v, tcol_in, len_in, 31'd0,
                             (hits_in[16] && len_in == 32'd4) && !(hits_in[0] || hits_in[1] ||
                             |hits_in[15:4]) ? 1'b1 : 1'b0, 8'd0};
               ntok++;
            end
            M_NUMBER, M_NUM_DOT: begin
               c = (mode_in == M_NUM_DOT) ? len_in - 32'd1 : len_in;
               tok[ntok] = acc_in[31]
                  ? '{K_ERR, E_OVERFLOW, v, tcol_in, c, 31'd0, 1'b0, 8'd0}
                  : '{K_NUMB, E_NONE, v, tcol_in, c, acc_in[30:0], 1'b0, 8'd0};
               ntok++;
               if (mode_in == M_NUM_DOT) begin
                  c = dot_col(tcol_in, len_in);
                  tok[ntok] = '{K_DOT, E_NONE, v, c, 32'd1, 31'd0, 1'b0, 8'd0}; ntok++;
               end
            end
            M_REAL: begin
               tok[ntok] = '{K_REAL, E_NONE, v, tcol_in, len_in, 31'd0, 1'b0, 8'd0}; ntok++;
            end
            M_TEXT: begin
               tok[ntok] = '{K_ERR, E_TEXT_OPEN, v, tcol_in, len_in, 31'd0, 1'b0, 8'd0}; ntok++;
            end
            M_CHAR_OPEN: begin
               tok[ntok] = '{K_ERR, E_CHAR_EMPTY, v, tcol_in, len_in, 31'd0, 1'b0, 8'd0};
               ntok++;
            end
            M_CHAR_VALUE: begin
               tok[ntok] = '{K_ERR, E_CHAR_OPEN, v, tcol_in, len_in, 31'd0, 1'b0, 8'd0}; ntok++;
            end
            M_HASH1, M_LINE: begin
               tok[ntok] = '{K_COMMENT, E_NONE, v, tcol_in, len_in, 31'd0, 1'b0, 8'd0}; ntok++;
            end
            M_BLOCK, M_BLOCK_HASH: begin
               tok[ntok] = '{K_ERR, E_BLOCK_OPEN, v, tcol_in, len_in, 31'd0, 1'b0, 8'd0};
               ntok++;
            end
            M_OP: begin
               tok[ntok] = op_tok(held_in, v, tcol_in, len_in); ntok++;
            end
            default: ;
         endcase
         mode_in = M_IDLE; held_in = 8'd0; line_in = 32'd1; col_in = 32'd1; tcol_in = 32'd1;
         len_in = 32'd0; acc_in = 32'd0; hits_in = AllHits; prev_in = 8'd0; space_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; held_ff <= 8'd0; prev_ff <= 8'd0;
         line_ff <= 32'd1; col_ff <= 32'd1; tcol_ff <= 32'd1; len_ff <= 32'd0;
         acc_ff <= 32'd0; hits_ff <= AllHits; space_ff <= 1'b0;
         qcnt_ff <= 2'd0; qhead_ff <= 2'd0;
      end else begin
         if (fire) begin
            mode_ff <= mode_in; held_ff <= held_in; prev_ff <= prev_in;
            line_ff <= line_in; col_ff <= col_in; tcol_ff <= tcol_in; len_ff <= len_in;
            acc_ff <= acc_in; hits_ff <= hits_in; space_ff <= space_in;
            qcnt_ff <= ntok; qhead_ff <= 2'd0;
            for (int i = 0; i < MaxResults; i++) q_ff[i] <= tok[i];
         end else if (rsp_tvalid && rsp_tready) begin
            qcnt_ff <= qcnt_ff - 2'd1;
            qhead_ff <= qhead_ff + 2'd1;
         end
      end
   end

   token_type head;
   assign head = q_ff[qhead_ff];
   assign rsp_tvalid = qcnt_ff != 2'd0;
   assign rsp_tlast = qcnt_ff == 2'd1;
   assign rsp_tdata = RspBits'({head.cval, head.bval, head.ival, head.len[PB-1:0],
                                head.col[PB-1:0], head.line[PB-1:0], head.err, head.kind});

`include "source_text_tokenizer_assert.svh"
   `STT_ASSERT_IMP(a_ready_when_empty, qcnt_ff == 2'd0, req_tready, "not ready with empty queue")
   `STT_ASSERT_IMP(a_head_in_range, rsp_tvalid, {1'b0, qhead_ff} + {1'b0, qcnt_ff} <= 3'd3, "queue overrun")
   `STT_ASSERT_NEXT(a_last_drains, rsp_tvalid && rsp_tlast && rsp_tready && !fire,
                    !rsp_tvalid, "queue not drained after last token")
endmodule

[verif/tb_source_text_tokenizer.sv]
`timescale 1ns / 1ps
module tb_source_text_tokenizer;
   import stt_pkg::*;

   localparam logic [5:0] K_LPAREN = 6'd25, K_RPAREN = 6'd26, K_LBRACE = 6'd27;
   localparam logic [5:0] K_RBRACE = 6'd28, K_LBRACK = 6'd29, K_RBRACK = 6'd30;
   localparam logic [5:0] K_COMMA = 6'd31, K_SEMI = 6'd33, K_PERCENT = 6'd34;
   localparam logic [5:0] K_CARET = 6'd35, K_PLUS = 6'd36, K_PLUS_EQ = 6'd37;
   localparam logic [5:0] K_MINUS = 6'd38, K_MINUS_EQ = 6'd39, K_STAR = 6'd40;
   localparam logic [5:0] K_STAR_EQ = 6'd41, K_SLASH = 6'd42, K_SLASH_EQ = 6'd43;
   localparam logic [5:0] K_BANG = 6'd44, K_BANG_EQ = 6'd45, K_ASSIGN = 6'd46;
   localparam logic [5:0] K_EQ_EQ = 6'd47, K_LT = 6'd48, K_LT_EQ = 6'd49;
   localparam logic [5:0] K_GT = 6'd50, K_GT_EQ = 6'd51, K_SHR = 6'd52;
   localparam logic [5:0] K_AND_AND = 6'd53, K_OR_OR = 6'd54;
   localparam logic [5:0] K_KEYWORD0 = 6'd9;
   localparam int TrueIndex = 16;
   localparam logic [15:0] PosMax = 16'hFFFF;

   typedef struct packed {
      logic [5:0]  kind;
      logic [3:0]  err;
      logic [15:0] line;
      logic [15:0] col;
      logic [15:0] len;
      logic [30:0] ival;
      logic        bval;
      logic [7:0]  cval;
      logic        last;
   } scan_token_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // source_byte
   logic         req_tlast;   // end_of_source
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;   // token_kind, error_kind, line_number_out, start_column,
                              // token_length, integer_value, bool_value, char_value
   logic         rsp_tlast;   // last_of_run

   source_text_tokenizer i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   scan_token_type expected_tokens[$];
   scan_token_type step_tokens[$];
   int     error_count;
   int     hold_cycles;
   bit     ready_quiet;

   string  kw_word[18];
   logic [3:0]  scan_mode;
   logic [7:0]  held_byte, previous_byte;
   logic [15:0] line_count, column_count, token_column, length_count;
   logic [31:0] number_acc;
   logic [17:0] keyword_hits;
   logic        trailing_space;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == PosMax) ? v : v + 16'd1;
   endfunction

   function automatic bit digit_byte(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit alpha_byte(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   task automatic scanner_reset();
      scan_mode = M_IDLE;
      held_byte = '0;
      line_count = 16'd1;
      column_count = 16'd1;
      token_column = 16'd1;
      length_count = '0;
      number_acc = '0;
      keyword_hits = '1;
      previous_byte = '0;
      trailing_space = 1'b0;
   endtask

   task automatic push_token(input logic [5:0] kind, input logic [3:0] err,
                             input logic [15:0] col, input logic [15:0] len,
                             input logic [30:0] ival, input logic bval,
                             input logic [7:0] cval);
      scan_token_type t;
      t.kind = kind;
      t.err = err;
      t.line = line_count;
      t.col = col;
      t.len = len;
      t.ival = ival;
      t.bval = bval;
      t.cval = cval;
      t.last = 1'b0;
      if (step_tokens.size() < MaxResults) step_tokens.insert(step_tokens.size(), t);
   endtask

   task automatic push_plain(input logic [5:0] kind, input logic [3:0] err);
      push_token(kind, err, token_column, length_count, '0, 1'b0, '0);
   endtask

   task automatic take_byte();
      length_count = sat_inc(length_count);
      column_count = sat_inc(column_count);
   endtask

   function automatic logic [17:0] narrow_hits(input logic [17:0] h, input logic [7:0] b,
                                               input int pos);
      for (int k = 0; k < 18; k++) begin
         if (h[k] && !(pos < kw_word[k].len() && kw_word[k][pos] == b)) h[k] = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
      if (b == "=") begin
         case (a)
            "+": return K_PLUS_EQ;
            "-": return K_MINUS_EQ;
            "*": return K_STAR_EQ;
            "/": return K_SLASH_EQ;
            "!": return K_BANG_EQ;
            "=": return K_EQ_EQ;
            "<": return K_LT_EQ;
            ">": return K_GT_EQ;
            default: ;
         endcase
      end
      if (a == ">" && b == ">") return K_SHR;
      if (a == "&" && b == "&") return K_AND_AND;
      if (a == "|" && b == "|") return K_OR_OR;
      return K_EOF;
   endfunction

   task automatic close_operator();
      case (held_byte)
         "+": push_plain(K_PLUS, E_NONE);
         "-": push_plain(K_MINUS, E_NONE);
         "*": push_plain(K_STAR, E_NONE);
         "/": push_plain(K_SLASH, E_NONE);
         "!": push_plain(K_BANG, E_NONE);
         "=": push_plain(K_ASSIGN, E_NONE);
         "<": push_plain(K_LT, E_NONE);
         ">": push_plain(K_GT, E_NONE);
         "&": push_plain(K_ERR, E_LONE_AMP);
         default: push_plain(K_ERR, E_LONE_BAR);
      endcase
   endtask

   task automatic close_word();
      for (int k = 0; k < 18; k++) begin
         if (keyword_hits[k] && kw_word[k].len() == length_count) begin
            push_token(k < TrueIndex ? K_KEYWORD0 + 6'(k) : K_BOOL, E_NONE, token_column,
                       length_count, '0, k == TrueIndex, '0);
            return;
         end
      end
      push_plain(K_IDENT, E_NONE);
   endtask

   task automatic close_number(input logic [15:0] len);
      if (number_acc[31]) push_token(K_ERR, E_OVERFLOW, token_column, len, '0, 1'b0, '0);
      else push_token(K_NUMB, E_NONE, token_column, len, number_acc[30:0], 1'b0, '0);
   endtask

   task automatic close_number_dot();
      logic [16:0] c;
      c = token_column + length_count - 17'd1;
      close_number(length_count - 16'd1);
      push_token(K_DOT, E_NONE, c > PosMax ? PosMax : c[15:0], 16'd1, '0, 1'b0, '0);
   endtask

   task automatic begin_token(input logic [7:0] b);
      logic [5:0] k;
      scan_mode = M_IDLE;
      if (b == " " || b == 8'h0D || b == 8'h09) begin
         column_count = sat_inc(column_count);
         trailing_space = 1'b1;
         return;
      end
      if (b == 8'h0A) begin
         line_count = sat_inc(line_count);
         column_count = 16'd1;
         trailing_space = 1'b1;
         return;
      end
      trailing_space = 1'b0;
      token_column = column_count;
      length_count = '0;
      take_byte();
      if (digit_byte(b)) begin
         number_acc = 32'(b - "0");
         scan_mode = M_NUMBER;
      end else if (alpha_byte(b)) begin
         keyword_hits = narrow_hits('1, b, 0);
         scan_mode = M_IDENT;
      end else if (b == "\"") begin
         previous_byte = b;
         scan_mode = M_TEXT;
      end else if (b == "'") begin
         scan_mode = M_CHAR_OPEN;
      end else if (b == "#") begin
         scan_mode = M_HASH1;
      end else if (b inside {"+", "-", "*", "/", "!", "=", "<", ">", "&", "|"}) begin
         held_byte = b;
         scan_mode = M_OP;
      end else begin
         case (b)
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            "[": k = K_LBRACK;
            "]": k = K_RBRACK;
            ",": k = K_COMMA;
            ".": k = K_DOT;
            ";": k = K_SEMI;
            "%": k = K_PERCENT;
            "^": k = K_CARET;
            default: k = K_EOF;
         endcase
         if (k != K_EOF) push_plain(k, E_NONE);
         else push_plain(K_ERR, E_UNEXPECTED);
      end
   endtask

   task automatic scan_byte(input logic [7:0] b);
      logic [5:0] k;
      logic [63:0] v;
      case (scan_mode)
         M_IDENT: begin
            if (digit_byte(b) || alpha_byte(b)) begin
               keyword_hits = narrow_hits(keyword_hits, b, length_count);
               take_byte();
               return;
            end
            close_word();
         end
         M_NUMBER: begin
            if (digit_byte(b)) begin
               if (!number_acc[31]) begin
                  v = number_acc * 64'd10 + 64'(b - "0");
                  number_acc = (v > AccMax) ? AccOvf : v[31:0];
               end
               take_byte();
               return;
            end
            if (b == ".") begin
               take_byte();
               scan_mode = M_NUM_DOT;
               return;
            end
            close_number(length_count);
         end
         M_NUM_DOT: begin
            if (digit_byte(b)) begin
               take_byte();
               scan_mode = M_REAL;
               return;
            end
            close_number_dot();
         end
         M_REAL: begin
            if (digit_byte(b)) begin
               take_byte();
               return;
            end
            push_plain(K_REAL, E_NONE);
         end
         M_TEXT: begin
            take_byte();
            if (b == "\"" && previous_byte != "\\") begin
               push_plain(K_TEXT, E_NONE);
               scan_mode = M_IDLE;
            end else begin
               previous_byte = b;
            end
            return;
         end
         M_CHAR_OPEN: begin
            if (b == "'") begin
               push_plain(K_ERR, E_CHAR_EMPTY);
            end else begin
               held_byte = b;
               take_byte();
               scan_mode = M_CHAR_VALUE;
               return;
            end
         end
         M_CHAR_VALUE: begin
            if (b == "'") begin
               take_byte();
               push_token(K_CHAR, E_NONE, token_column, length_count, '0, 1'b0, held_byte);
               scan_mode = M_IDLE;
               return;
            end
            push_plain(K_ERR, E_CHAR_OPEN);
         end
         M_HASH1: begin
            if (b == 8'h0A) begin
               push_plain(K_COMMENT, E_NONE);
            end else begin
               take_byte();
               scan_mode = (b == "#") ? M_BLOCK : M_LINE;
               return;
            end
         end
         M_LINE: begin
            if (b == 8'h0A) begin
               push_plain(K_COMMENT, E_NONE);
            end else begin
               take_byte();
               return;
            end
         end
         M_BLOCK: begin
            take_byte();
            if (b == "#") scan_mode = M_BLOCK_HASH;
            return;
         end
         M_BLOCK_HASH: begin
            take_byte();
            if (b == "#") begin
               push_plain(K_COMMENT, E_NONE);
               scan_mode = M_IDLE;
            end else begin
               scan_mode = M_BLOCK;
            end
            return;
         end
         M_OP: begin
            k = pair_kind(held_byte, b);
            if (k != K_EOF) begin
               take_byte();
               push_plain(k, E_NONE);
               scan_mode = M_IDLE;
               return;
            end
            close_operator();
         end
         default: ;
      endcase
      begin_token(b);
   endtask

   task automatic flush_source();
      case (scan_mode)
         M_IDLE: if (trailing_space) push_token(K_EOF, E_NONE, column_count, '0, '0, 1'b0, '0);
         M_IDENT: close_word();
         M_NUMBER: close_number(length_count);
         M_NUM_DOT: close_number_dot();
         M_REAL: push_plain(K_REAL, E_NONE);
         M_TEXT: push_plain(K_ERR, E_TEXT_OPEN);
         M_CHAR_OPEN: push_plain(K_ERR, E_CHAR_EMPTY);
         M_CHAR_VALUE: push_plain(K_ERR, E_CHAR_OPEN);
         M_HASH1, M_LINE: push_plain(K_COMMENT, E_NONE);
         M_BLOCK, M_BLOCK_HASH: push_plain(K_ERR, E_BLOCK_OPEN);
         M_OP: close_operator();
         default: ;
      endcase
   endtask

   task automatic predict_tokens(input logic [7:0] b, input logic fin);
      step_tokens.delete();
      scan_byte(b);
      if (fin) begin
         flush_source();
         scanner_reset();
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      predict_tokens(b, fin);
   endtask

   task automatic send_text(input string s, input bit fin);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
   endtask

   function automatic string random_fragment();
      string s;
      string head_set, tail_set, op_first, op_second, punct_set;
      int n;
      head_set = "aZ_x";
      tail_set = "a9Q_";
      op_first = "+-*/!=<>&|";
      op_second = "=>&|+";
      punct_set = "(){}[],.;%^";
      case ($urandom_range(0, 13))
         0: s = kw_word[$urandom_range(0, 17)];
         1: begin
            n = $urandom_range(1, 6);
            s = "";
            for (int i = 0; i < n; i++)
               s = {s, string'(i == 0 ? head_set[$urandom_range(0, 3)]
                                      : tail_set[$urandom_range(0, 3)])};
         end
         2: s = $sformatf("%0d", $urandom_range(0, 99999));
         3: s = ($urandom_range(0, 1) == 0) ? "2147483647" : "99999999999";
         4: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 999));
         5: s = $sformatf("\"t%0d\\\"q\"", $urandom_range(0, 9));
         6: s = {"'", string'(8'($urandom_range(32, 126))), "'"};
         7: s = "# note\n";
         8: s = "## blk # x\n##";
         9: s = {string'(op_first[$urandom_range(0, 9)]),
                 string'(op_second[$urandom_range(0, 4)])};
         10: s = string'(punct_set[$urandom_range(0, 10)]);
         11: s = ($urandom_range(0, 1) == 0) ? " " : "\n";
         12: s = string'(8'($urandom_range(0, 255)));
         default: s = ($urandom_range(0, 1) == 0) ? "\t" : "7.";
      endcase
      return s;
   endfunction

   task automatic test_directed_tokens();
      send_text("if x1 >>= 2147483648 ", 1);
      send_text("true false\n", 1);
      send_text("12.a ''", 1);
      send_text("'q' \"a\\\"b\"#c\n## z ##&& || & |", 1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("\"open", 1);
   endtask

   task automatic test_random_text();
      int sent;
      string s;
      sent = 0;
      while (sent < 110) begin
         s = random_fragment();
         if ($urandom_range(0, 2) == 0) s = {s, " "};
         for (int i = 0; i < s.len(); i++) begin
            sent++;
            send_byte(s[i], $urandom_range(0, 24) == 0);
         end
      end
      send_byte(" ", 1'b1);
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      for (int i = 0; i < 40; i++) send_byte(i[0] ? "(" : "x", i == 39);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      error_count = 0;
      hold_cycles = 0;
      ready_quiet = 1'b0;
      kw_word = '{"f", "data", "mut", "if", "else", "while", "match", "case", "none",
                  "return", "include", "numb", "real", "bool", "char", "text", "true",
                  "false"};
      kw_word[0] = {kw_word[0], "unk"};
      scanner_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_tokens();
      test_random_text();
      test_backpressure();
      req_tvalid <= 1'b0;
      while (expected_tokens.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int stall;
      scan_token_type e;
      scan_token_type got;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tdata[5:0];
            got.err = rsp_tdata[9:6];
            got.line = rsp_tdata[25:10];
            got.col = rsp_tdata[41:26];
            got.len = rsp_tdata[57:42];
            got.ival = rsp_tdata[88:58];
            got.bval = rsp_tdata[89];
            got.cval = rsp_tdata[97:90];
            got.last = rsp_tlast;
            if (expected_tokens.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("unexpected token kind %0d", got.kind);
            end else begin
               e = expected_tokens.pop_front();
               if (got !== e) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch: expected %p, actual %p", e, got);
               end
            end
            stall = ready_quiet ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 31) == 0) ready_quiet = ~ready_quiet;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_kw_match.sv
rtl/source_text_tokenizer.sv
verif/tb_source_text_tokenizer.sv
